@@ src/dqb_pkg.sv @@
// Shared constants, types and helpers for the dual-quaternion blend pipeline.
// Used by every module under src; depends on nothing.
package dqb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COMP_W      = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int WEIGHT_W    = WEIGHT_BITS + 1;
    localparam int NUM_COMP    = 8;
    localparam int NUM_REAL    = 4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_BITS;

    typedef logic signed [COMP_W-1:0] comp_t;

    localparam logic signed [63:0] COMP_MAX    = 64'sd2147483647;
    localparam logic signed [63:0] WEIGHT_HALF = 64'sd1 <<< (WEIGHT_BITS - 1);
    localparam logic signed [63:0] FRAC_HALF   = 64'sd1 <<< (FRAC_BITS - 1);

    // blend products: 32b signed x 18b signed
    localparam int BL_W = COMP_W + WEIGHT_W + 1;

    // length and square root
    localparam int SQ_W        = 2 * COMP_W;
    localparam int ROOT_W      = COMP_W;
    localparam int SQRT_STAGES = SQ_W / 2;
    localparam int SQRT_REM_W  = ROOT_W + 4;
    localparam logic [SQ_W-1:0] EPS_SQ_LIMIT =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000;

    // rounded division: numerator 2*|c|*2^F + len, divisor 2*len
    localparam int NUM_W   = COMP_W + FRAC_BITS + 1;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int DIV_REM_W = DEN_W + 1;

    // projection widths
    localparam int RN_W = FRAC_BITS + 2;
    localparam int PR_W = COMP_W + RN_W;
    localparam int PS_W = PR_W + 2;
    localparam int PJ_W = PS_W - FRAC_BITS;
    localparam int RP_W = RN_W + PJ_W;

    // pipeline stage numbers (stage n is the nth register after the input)
    localparam int ST_C    = 3;
    localparam int ST_SUM  = ST_C + 2;
    localparam int ST_ROOT = ST_SUM + SQRT_STAGES;
    localparam int ST_Q    = ST_ROOT + 1 + NUM_W;
    localparam int ST_N    = ST_Q + 1;
    localparam int ST_OUT  = ST_N + 4;

    typedef struct packed {
        logic [63:0] real_xy;
        logic [63:0] real_zw;
        logic [63:0] dual_xy;
        logic [63:0] dual_zw;
        logic        degenerate;
    } res_t;

    function automatic comp_t sat_comp(input logic signed [63:0] v);
        comp_t r;
        if (v > COMP_MAX) begin
            r = COMP_W'(COMP_MAX);
        end else if (v < -COMP_MAX) begin
            r = COMP_W'(-COMP_MAX);
        end else begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/dqb_blend.sv @@
// One blend lane: c = sat(floor((a*(1-t) + b*t*sign + half) / 2^16)).
// Three register stages; depends on dqb_pkg. Sign arrives at stage two.
module dqb_blend import dqb_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  comp_t               a,
    input  comp_t               b,
    input  logic [WEIGHT_W-1:0] t,
    input  logic                neg,
    output comp_t               c
);

    logic signed [BL_W-1:0] pa1_reg, pb1_reg, pa2_reg, pb2_reg;
    comp_t                  c_reg;
    logic signed [63:0]     acc;
    logic [WEIGHT_W-1:0]    t_inv;

    assign t_inv = WEIGHT_ONE - t;

    always_comb begin
        if (neg) begin
            acc = 64'(pa2_reg) - 64'(pb2_reg) + WEIGHT_HALF;
        end else begin
            acc = 64'(pa2_reg) + 64'(pb2_reg) + WEIGHT_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa1_reg <= a * signed'({1'b0, t_inv});
            pb1_reg <= b * signed'({1'b0, t});
            pa2_reg <= pa1_reg;
            pb2_reg <= pb1_reg;
            c_reg   <= sat_comp(acc >>> WEIGHT_BITS);
        end
    end

    assign c = c_reg;

endmodule

@@ src/dqb_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on dqb_pkg.
module dqb_isqrt import dqb_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   sq,
    output logic [ROOT_W-1:0] root
);

    logic [SQRT_REM_W-1:0] rem_reg  [1:SQRT_STAGES];
    logic [ROOT_W-1:0]     root_reg [1:SQRT_STAGES];
    logic [SQ_W-1:0]       sq_reg   [1:SQRT_STAGES];

    genvar k;
    for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [SQRT_REM_W-1:0] rem_in, rem_sh, trial;
        logic [ROOT_W-1:0]     root_in;
        logic [SQ_W-1:0]       sq_in;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign sq_in   = sq;
        end else begin : g_rest
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign sq_in   = sq_reg[k];
        end

        assign rem_sh = {rem_in[SQRT_REM_W-3:0], sq_in[SQ_W-1 -: 2]};
        assign trial  = SQRT_REM_W'({root_in, 2'b01});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    rem_reg[k+1]  <= rem_sh - trial;
                    root_reg[k+1] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= rem_sh;
                    root_reg[k+1] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                sq_reg[k+1] <= sq_in << 2;
            end
        end
    end

    assign root = root_reg[SQRT_STAGES];

endmodule

@@ src/dqb_div.sv @@
// Pipelined rounded divide: round(c * 2^F / len), half away from zero.
// Restoring, one quotient bit per stage; depends on dqb_pkg.
module dqb_div import dqb_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  comp_t                 c,
    input  logic [ROOT_W-1:0]     len,
    output logic signed [NUM_W:0] q
);

    logic [NUM_W-1:0]     num_reg [0:NUM_W];
    logic [DEN_W-1:0]     den_reg [0:NUM_W];
    logic [DIV_REM_W-1:0] rem_reg [0:NUM_W];
    logic [NUM_W-1:0]     quo_reg [0:NUM_W];
    logic                 neg_reg [0:NUM_W];
    logic [COMP_W-1:0]    mag;

    assign mag = c[COMP_W-1] ? COMP_W'(-c) : COMP_W'(c);

    // load: form 2*|c|*2^F + len and 2*len
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= {mag, {FRAC_BITS{1'b0}}, 1'b0} + NUM_W'(len);
            den_reg[0] <= {len, 1'b0};
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            neg_reg[0] <= c[COMP_W-1];
        end
    end

    genvar k;
    for (k = 0; k < NUM_W; k++) begin : g_stage
        logic [DIV_REM_W-1:0] rem_sh;
        logic                 ge;

        assign rem_sh = {rem_reg[k][DIV_REM_W-2:0], num_reg[k][NUM_W-1]};
        assign ge     = rem_sh >= {1'b0, den_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? rem_sh - {1'b0, den_reg[k]} : rem_sh;
                quo_reg[k+1] <= {quo_reg[k][NUM_W-2:0], ge};
                num_reg[k+1] <= num_reg[k] << 1;
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign q = neg_reg[NUM_W] ? -signed'({1'b0, quo_reg[NUM_W]})
                              : signed'({1'b0, quo_reg[NUM_W]});

endmodule

@@ src/dual_quat_blend_normalize.sv @@
// Throughput: one word per cycle while the skid stage is empty; eight blend lanes and eight
// divide lanes, one bit per stage in the 32-stage square root and the 50-stage dividers
// (load plus 49 bit stages).
// Reset: aresetn (synchronous, active low) clears the valid bits of the pipeline,
// output register and skid stage; payload registers are not reset.
module dual_quat_blend_normalize import dqb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [63:0]         s_a_real_xy,
    input  logic [63:0]         s_a_real_zw,
    input  logic [63:0]         s_a_dual_xy,
    input  logic [63:0]         s_a_dual_zw,
    input  logic [63:0]         s_b_real_xy,
    input  logic [63:0]         s_b_real_zw,
    input  logic [63:0]         s_b_dual_xy,
    input  logic [63:0]         s_b_dual_zw,
    input  logic [WEIGHT_W-1:0] s_weight,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [63:0]         m_out_real_xy,
    output logic [63:0]         m_out_real_zw,
    output logic [63:0]         m_out_dual_xy,
    output logic [63:0]         m_out_dual_zw,
    output logic                m_degenerate
);

    // Whole pipeline advances together; it halts only while the skid stage holds a word.
    logic en;

    comp_t               a [0:NUM_COMP-1];
    comp_t               b [0:NUM_COMP-1];
    comp_t               c [0:NUM_COMP-1];
    logic [WEIGHT_W-1:0] t;

    logic vld_reg [1:ST_OUT];

    // sign test on the real parts
    logic signed [SQ_W-1:0] dp_reg [0:NUM_REAL-1];
    logic                   neg_reg;
    logic signed [SQ_W+1:0] dot_sum;

    // length
    logic [SQ_W-1:0]   sq_reg [0:NUM_REAL-1];
    logic [SQ_W-1:0]   sum_reg;
    logic [ROOT_W-1:0] root;

    // raw blend and degenerate flag ride alongside the maths
    comp_t c_pipe_reg   [ST_C+1:ST_OUT-1][0:NUM_COMP-1];
    logic  deg_pipe_reg [ST_SUM+1:ST_OUT-1];

    // divide results
    logic signed [NUM_W:0] q [0:NUM_COMP-1];

    // projection pipeline
    logic signed [RN_W-1:0] rn_reg [0:2][0:NUM_REAL-1];
    comp_t                  rn3_reg [0:NUM_REAL-1];
    comp_t                  dn_reg [0:3][0:NUM_REAL-1];
    logic signed [PR_W-1:0] pr_reg [0:NUM_REAL-1];
    logic signed [PJ_W-1:0] proj_reg;
    logic signed [RP_W-1:0] rp_reg [0:NUM_REAL-1];
    logic signed [PS_W-1:0] proj_sum;
    logic signed [PS_W-1:0] proj_full;

    // final stage, output register, skid
    res_t fin_reg, fin_next;
    res_t out_reg, skid_reg;
    logic out_vld_reg, skid_vld_reg;
    comp_t dual_fin [0:NUM_REAL-1];

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    // unpack: x/z in the low half
    assign a[0] = s_a_real_xy[31:0];
    assign a[1] = s_a_real_xy[63:32];
    assign a[2] = s_a_real_zw[31:0];
    assign a[3] = s_a_real_zw[63:32];
    assign a[4] = s_a_dual_xy[31:0];
    assign a[5] = s_a_dual_xy[63:32];
    assign a[6] = s_a_dual_zw[31:0];
    assign a[7] = s_a_dual_zw[63:32];
    assign b[0] = s_b_real_xy[31:0];
    assign b[1] = s_b_real_xy[63:32];
    assign b[2] = s_b_real_zw[31:0];
    assign b[3] = s_b_real_zw[63:32];
    assign b[4] = s_b_dual_xy[31:0];
    assign b[5] = s_b_dual_xy[63:32];
    assign b[6] = s_b_dual_zw[31:0];
    assign b[7] = s_b_dual_zw[63:32];

    // clamp a weight above one to one
    assign t = (s_weight > WEIGHT_ONE) ? WEIGHT_ONE : s_weight;

    // valid bits: advance with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= ST_OUT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[1] <= s_valid;
            for (int k = 2; k <= ST_OUT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // exact dot product of the real parts; zero counts as not negative
    always_comb begin
        dot_sum = '0;
        for (int i = 0; i < NUM_REAL; i++) begin
            dot_sum = dot_sum + (SQ_W+2)'(dp_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_REAL; i++) begin
                dp_reg[i] <= a[i] * b[i];
            end
            neg_reg <= dot_sum[SQ_W+1];
        end
    end

    // blend lanes
    genvar g;
    for (g = 0; g < NUM_COMP; g++) begin : g_blend
        dqb_blend u_blend (
            .aclk (aclk),
            .en   (en),
            .a    (a[g]),
            .b    (b[g]),
            .t    (t),
            .neg  (neg_reg),
            .c    (c[g])
        );
    end

    // squared length of the blended real part
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_REAL; i++) begin
                sq_reg[i] <= SQ_W'(64'(c[i]) * 64'(c[i]));
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
        end
    end

    dqb_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .sq   (sum_reg),
        .root (root)
    );

    // carry the raw blend and the flag down to the final stage
    always_ff @(posedge aclk) begin
        if (en) begin
            c_pipe_reg[ST_C+1] <= c;
            for (int k = ST_C + 2; k <= ST_OUT - 1; k++) begin
                c_pipe_reg[k] <= c_pipe_reg[k-1];
            end
            deg_pipe_reg[ST_SUM+1] <= sum_reg < EPS_SQ_LIMIT;
            for (int k = ST_SUM + 2; k <= ST_OUT - 1; k++) begin
                deg_pipe_reg[k] <= deg_pipe_reg[k-1];
            end
        end
    end

    // divide lanes: all eight components by the length
    for (g = 0; g < NUM_COMP; g++) begin : g_div
        dqb_div u_div (
            .aclk (aclk),
            .en   (en),
            .c    (c_pipe_reg[ST_ROOT][g]),
            .len  (root),
            .q    (q[g])
        );
    end

    // merge: dot of dual and real, then remove the projection
    always_comb begin
        proj_sum = '0;
        for (int i = 0; i < NUM_REAL; i++) begin
            proj_sum = proj_sum + PS_W'(pr_reg[i]);
        end
        proj_full = (proj_sum + PS_W'(FRAC_HALF)) >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_REAL; i++) begin
                // real quotients stay within one; dual ones saturate
                rn_reg[0][i]  <= q[i][RN_W-1:0];
                dn_reg[0][i]  <= sat_comp(64'(q[NUM_REAL+i]));
                pr_reg[i]     <= dn_reg[0][i] * rn_reg[0][i];
                rn_reg[1][i]  <= rn_reg[0][i];
                dn_reg[1][i]  <= dn_reg[0][i];
                rn_reg[2][i]  <= rn_reg[1][i];
                dn_reg[2][i]  <= dn_reg[1][i];
                rp_reg[i]     <= rn_reg[2][i] * proj_reg;
                rn3_reg[i]    <= COMP_W'(rn_reg[2][i]);
                dn_reg[3][i]  <= dn_reg[2][i];
            end
            proj_reg <= proj_full[PJ_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_REAL; i++) begin
            dual_fin[i] = sat_comp(64'(dn_reg[3][i])
                                   - ((64'(rp_reg[i]) + FRAC_HALF) >>> FRAC_BITS));
        end
        if (deg_pipe_reg[ST_OUT-1]) begin
            fin_next.real_xy = {c_pipe_reg[ST_OUT-1][1], c_pipe_reg[ST_OUT-1][0]};
            fin_next.real_zw = {c_pipe_reg[ST_OUT-1][3], c_pipe_reg[ST_OUT-1][2]};
            fin_next.dual_xy = {c_pipe_reg[ST_OUT-1][5], c_pipe_reg[ST_OUT-1][4]};
            fin_next.dual_zw = {c_pipe_reg[ST_OUT-1][7], c_pipe_reg[ST_OUT-1][6]};
        end else begin
            fin_next.real_xy = {rn3_reg[1], rn3_reg[0]};
            fin_next.real_zw = {rn3_reg[3], rn3_reg[2]};
            fin_next.dual_xy = {dual_fin[1], dual_fin[0]};
            fin_next.dual_zw = {dual_fin[3], dual_fin[2]};
        end
        fin_next.degenerate = deg_pipe_reg[ST_OUT-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fin_next;
        end
    end

    // output register plus skid: hold the pipeline only when both are full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                out_reg      <= skid_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (vld_reg[ST_OUT]) begin
            if (!out_vld_reg || m_ready) begin
                out_reg     <= fin_reg;
                out_vld_reg <= 1'b1;
            end else begin
                skid_reg     <= fin_reg;
                skid_vld_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_out_real_xy = out_reg.real_xy;
    assign m_out_real_zw = out_reg.real_zw;
    assign m_out_dual_xy = out_reg.dual_xy;
    assign m_out_dual_zw = out_reg.dual_zw;
    assign m_degenerate  = out_reg.degenerate;

endmodule

@@ tb/dual_quat_blend_normalize_tb.sv @@
// Self-checking testbench for dual_quat_blend_normalize: directed and random words,
// predicted by an independent model of the blend and normalisation. Depends on dqb_pkg.
module dual_quat_blend_normalize_tb;
    import dqb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    // One input word: operand A and B halves in port order, then the weight.
    typedef struct {
        logic [63:0]         a [4];
        logic [63:0]         b [4];
        logic [WEIGHT_W-1:0] weight;
    } blend_word_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [63:0]         s_a_real_xy, s_a_real_zw, s_a_dual_xy, s_a_dual_zw;
    logic [63:0]         s_b_real_xy, s_b_real_zw, s_b_dual_xy, s_b_dual_zw;
    logic [WEIGHT_W-1:0] s_weight;
    logic                m_valid;
    logic                m_ready;
    logic [63:0]         m_out_real_xy, m_out_real_zw, m_out_dual_xy, m_out_dual_zw;
    logic                m_degenerate;

    // Pending blends, oldest first
    res_t blend_fifo[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int error_count    = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int degenerate_seen = 0;
    int negated_seen   = 0;

    dual_quat_blend_normalize u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_real_xy   (s_a_real_xy),
        .s_a_real_zw   (s_a_real_zw),
        .s_a_dual_xy   (s_a_dual_xy),
        .s_a_dual_zw   (s_a_dual_zw),
        .s_b_real_xy   (s_b_real_xy),
        .s_b_real_zw   (s_b_real_zw),
        .s_b_dual_xy   (s_b_dual_xy),
        .s_b_dual_zw   (s_b_dual_zw),
        .s_weight      (s_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_real_xy (m_out_real_xy),
        .m_out_real_zw (m_out_real_zw),
        .m_out_dual_xy (m_out_dual_xy),
        .m_out_dual_zw (m_out_dual_zw),
        .m_degenerate  (m_degenerate)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp symmetrically to the Q16.16 component range.
    function automatic wide_t clamp_comp(input wide_t v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483647) return -128'sd2147483647;
        return v;
    endfunction

    // Divide with rounding to nearest, ties away from zero.
    function automatic wide_t div_round(input wide_t n, input wide_t d);
        wide_t m;
        wide_t q;
        m = (n < 0) ? -n : n;
        q = (2 * m + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic wide_t floor_sqrt(input wide_t s);
        wide_t root;
        wide_t bitv;
        root = 0;
        bitv = wide_t'(1) <<< 62;
        while (bitv > s) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s    = s - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] pack_comps(input wide_t lo, input wide_t hi);
        return {hi[31:0], lo[31:0]};
    endfunction

    // Work out the normalised blend of one word.
    function automatic res_t blend_normalise(input blend_word_t w, output logic negated);
        wide_t a [8];
        wide_t b [8];
        wide_t c [8];
        wide_t rn [4];
        wide_t dn [4];
        wide_t t, dot, sq, len, s, proj, half;
        res_t  r;
        for (int i = 0; i < 4; i++) begin
            a[2*i]   = wide_t'($signed(w.a[i][31:0]));
            a[2*i+1] = wide_t'($signed(w.a[i][63:32]));
            b[2*i]   = wide_t'($signed(w.b[i][31:0]));
            b[2*i+1] = wide_t'($signed(w.b[i][63:32]));
        end
        t = wide_t'(w.weight);
        if (t > 65536) t = 65536;
        dot = 0;
        for (int i = 0; i < 4; i++) dot = dot + a[i] * b[i];
        negated = (dot < 0);
        for (int i = 0; i < 8; i++) begin
            c[i] = clamp_comp((a[i] * (65536 - t) + (negated ? -b[i] : b[i]) * t + 32768)
                              >>> 16);
        end
        sq = 0;
        for (int i = 0; i < 4; i++) sq = sq + c[i] * c[i];
        if (sq < wide_t'(EPS_SQ_LIMIT)) begin
            r.real_xy = pack_comps(c[0], c[1]);
            r.real_zw = pack_comps(c[2], c[3]);
            r.dual_xy = pack_comps(c[4], c[5]);
            r.dual_zw = pack_comps(c[6], c[7]);
            r.degenerate = 1'b1;
            return r;
        end
        len = floor_sqrt(sq);
        for (int i = 0; i < 4; i++) begin
            rn[i] = div_round(c[i] <<< FRAC_BITS, len);
            dn[i] = clamp_comp(div_round(c[4+i] <<< FRAC_BITS, len));
        end
        half = wide_t'(1) <<< (FRAC_BITS - 1);
        s = 0;
        for (int i = 0; i < 4; i++) s = s + dn[i] * rn[i];
        proj = (s + half) >>> FRAC_BITS;
        for (int i = 0; i < 4; i++) begin
            dn[i] = clamp_comp(dn[i] - ((rn[i] * proj + half) >>> FRAC_BITS));
        end
        r.real_xy = pack_comps(rn[0], rn[1]);
        r.real_zw = pack_comps(rn[2], rn[3]);
        r.dual_xy = pack_comps(dn[0], dn[1]);
        r.dual_zw = pack_comps(dn[2], dn[3]);
        r.degenerate = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one word, idling first at the current rate
    // ------------------------------------------------------------------
    task automatic send_word(input blend_word_t w);
        logic neg;
        res_t r;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_a_real_xy <= w.a[0];
        s_a_real_zw <= w.a[1];
        s_a_dual_xy <= w.a[2];
        s_a_dual_zw <= w.a[3];
        s_b_real_xy <= w.b[0];
        s_b_real_zw <= w.b[1];
        s_b_dual_xy <= w.b[2];
        s_b_dual_zw <= w.b[3];
        s_weight    <= w.weight;
        s_valid     <= 1'b1;
        // hold the word until the block takes it
        do @(posedge aclk); while (!s_ready);
        r = blend_normalise(w, neg);
        blend_fifo.push_back(r);
        words_sent++;
        if (r.degenerate) degenerate_seen++;
        if (neg) negated_seen++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a counted hold-off for back-pressure
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare every accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        res_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (blend_fifo.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result with nothing pending", $realtime);
            end else begin
                exp_r = blend_fifo.pop_front();
                words_checked++;
                if (m_out_real_xy !== exp_r.real_xy || m_out_real_zw !== exp_r.real_zw ||
                    m_out_dual_xy !== exp_r.dual_xy || m_out_dual_zw !== exp_r.dual_zw ||
                    m_degenerate !== exp_r.degenerate) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: mismatch on result %0d", $realtime, words_checked);
                        $display("  real_xy exp %h got %h", exp_r.real_xy, m_out_real_xy);
                        $display("  real_zw exp %h got %h", exp_r.real_zw, m_out_real_zw);
                        $display("  dual_xy exp %h got %h", exp_r.dual_xy, m_out_dual_xy);
                        $display("  dual_zw exp %h got %h", exp_r.dual_zw, m_out_dual_zw);
                        $display("  degenerate exp %b got %b", exp_r.degenerate,
                                 m_degenerate);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Pick one Q16.16 component: mostly unit-scale, some full range and extremes.
    function automatic logic [31:0] pick_comp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return 32'($signed($urandom_range(131072)) - 65536);
        if (sel < 70) return 32'($signed($urandom_range(2048)) - 1024);
        if (sel < 85) return $urandom;
        if (sel < 90) return 32'h7FFF_FFFF;
        if (sel < 95) return 32'h8000_0000;
        return 32'h0;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) return WEIGHT_W'($urandom_range(65536));
        if (sel < 85) return '0;
        if (sel < 90) return WEIGHT_ONE;
        return WEIGHT_W'($urandom);
    endfunction

    function automatic blend_word_t pick_word();
        blend_word_t w;
        int sel;
        for (int i = 0; i < 4; i++) begin
            w.a[i] = {pick_comp(), pick_comp()};
            w.b[i] = {pick_comp(), pick_comp()};
        end
        sel = $urandom_range(99);
        // drive some words with a zero real part into the degenerate path, some with B = -A at the midpoint
        if (sel < 5) begin
            w.a[0] = '0; w.a[1] = '0; w.b[0] = '0; w.b[1] = '0;
        end else if (sel < 10) begin
            w.b[0] = w.a[0]; w.b[1] = w.a[1];
            w.weight = WEIGHT_W'(32768);
            // B = -A in the real part; the negative dot product flips B back, so these blend to A
            w.b[0] = {32'(-$signed(w.a[0][63:32])), 32'(-$signed(w.a[0][31:0]))};
            w.b[1] = {32'(-$signed(w.a[1][63:32])), 32'(-$signed(w.a[1][31:0]))};
            return w;
        end
        w.weight = pick_weight();
        return w;
    endfunction

    function automatic blend_word_t fill_word(input logic [31:0] ar, input logic [31:0] ad,
                                              input logic [31:0] br, input logic [31:0] bd,
                                              input logic [WEIGHT_W-1:0] t);
        blend_word_t w;
        w.a[0] = {ar, ar}; w.a[1] = {ar, ar}; w.a[2] = {ad, ad}; w.a[3] = {ad, ad};
        w.b[0] = {br, br}; w.b[1] = {br, br}; w.b[2] = {bd, bd}; w.b[3] = {bd, bd};
        w.weight = t;
        return w;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) send_word(pick_word());
    endtask

    // Drop valid, then wait until every pending result has been taken.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (blend_fifo.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        blend_word_t w;
        send_idle_pct = 0; recv_stall_pct = 0;
        // all zero: degenerate, zero blend
        send_word(fill_word(32'h0, 32'h0, 32'h0, 32'h0, '0));
        // zero real part with live dual part stays unnormalised
        send_word(fill_word(32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000, WEIGHT_W'(30000)));
        // unit real parts, both weight ends and the midpoint
        send_word(fill_word(32'h0000_8000, 32'h0000_1000, 32'h0000_4000, 32'h0, '0));
        send_word(fill_word(32'h0000_8000, 32'h0000_1000, 32'h0000_4000, 32'h0, WEIGHT_ONE));
        send_word(fill_word(32'h0000_8000, 32'h0000_1000, 32'h0000_4000, 32'h0,
                            WEIGHT_W'(32768)));
        // weight above one is treated as one
        send_word(fill_word(32'h0000_8000, 32'h0000_1000, 32'h0000_4000, 32'h0,
                            WEIGHT_W'(17'h1FFFF)));
        send_word(fill_word(32'h0000_8000, 32'h0000_1000, 32'h0000_4000, 32'h0,
                            WEIGHT_W'(65537)));
        // opposite hemispheres: B is negated before blending
        send_word(fill_word(32'h0001_0000, 32'h0000_2000, 32'hFFFF_0000, 32'h0000_3000,
                            WEIGHT_W'(20000)));
        // extremes of the component range, blend overflow saturates
        send_word(fill_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            WEIGHT_W'(40000)));
        send_word(fill_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            WEIGHT_ONE));
        send_word(fill_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            '0));
        send_word(fill_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                            WEIGHT_W'(1)));
        send_word(fill_word(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
                            WEIGHT_W'(65535)));
        // real part of B is minus that of A at the midpoint: B is negated back, so the blend is A
        w = fill_word(32'h0001_0000, 32'h0000_5000, 32'h0, 32'h0, WEIGHT_W'(32768));
        w.b[0] = {32'hFFFF_0000, 32'h0001_0000}; w.b[1] = {32'hFFFF_0000, 32'h0001_0000};
        w.a[0] = {32'h0001_0000, 32'hFFFF_0000}; w.a[1] = {32'h0001_0000, 32'hFFFF_0000};
        send_word(w);
        // identity rotation with a translation
        w = fill_word(32'h0, 32'h0, 32'h0, 32'h0, WEIGHT_W'(12345));
        w.a[1] = {32'h0001_0000, 32'h0}; w.b[1] = {32'h0001_0000, 32'h0};
        w.a[2] = {32'h0002_0000, 32'h0003_0000}; w.b[2] = {32'hFFFE_0000, 32'h0000_8000};
        send_word(w);
        drain();
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(70);
        send_idle_pct = 51; recv_stall_pct = 0;  send_random(70);
        send_idle_pct = 0;  recv_stall_pct = 51; send_random(70);
        send_idle_pct = 10; recv_stall_pct = 10; send_random(70);
        drain();
    endtask

    // Hold the receiver off long enough to fill the pipeline and stall the input.
    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        @(negedge aclk);
        hold_cycles = 300;
        send_random(100);
        drain();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_a_real_xy = '0; s_a_real_zw = '0; s_a_dual_xy = '0; s_a_dual_zw = '0;
        s_b_real_xy = '0; s_b_real_zw = '0; s_b_dual_xy = '0; s_b_dual_zw = '0;
        s_weight    = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_phases();
        test_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        drain();
        // let the pipeline run dry in case anything stray is still in flight
        repeat (ST_OUT + 20) @(posedge aclk);
        if (blend_fifo.size() != 0) error_count++;

        $display("Checked %0d of %0d blends (%0d degenerate, %0d with B negated)",
                 words_checked, words_sent, degenerate_seen, negated_seen);
        $display("Idle, sender gaps, receiver stalls, mixed and a long hold-off covered");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("mismatches: %0d", error_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20.0 * 400000);
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ dual_quat_blend_normalize.f @@
src/dqb_pkg.sv
src/dqb_blend.sv
src/dqb_isqrt.sv
src/dqb_div.sv
src/dual_quat_blend_normalize.sv
tb/dual_quat_blend_normalize_tb.sv
